>>> sv/crp_pkg.sv
// Package for the citation reference parser: shared types and constants.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package crp_pkg;

    // Width of the name length and character index fields.
    localparam int LEN_W = 5;

    // Characters with a meaning in the line syntax.
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;

    localparam logic [19:0] RADIX   = 20'd10;
    localparam logic [15:0] NUM_MAX = 16'hFFFF;

    // Quoted field target that holds the book name.
    localparam logic [1:0] TGT_NAME = 2'd2;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_REF   = 2'd1,
        KIND_NULL  = 2'd2,
        KIND_ERROR = 2'd3
    } crp_kind_t;

    // One finished line handed from the parser to the result sequencer.
    typedef struct packed {
        logic              bad;
        logic [15:0]       chapter;
        logic [15:0]       verse;
        logic [LEN_W-1:0]  name_len;
    } crp_job_t;

    // Name store write request.
    typedef struct packed {
        logic              en;
        logic [LEN_W-1:0]  addr;
        logic [7:0]        data;
    } crp_wr_t;

    // Result descriptor without the name character.
    typedef struct packed {
        crp_kind_t    kind;
        logic [15:0]  chapter;
        logic [15:0]  verse;
        logic         last;
    } crp_res_t;

endpackage

`default_nettype wire

>>> sv/crp_if.sv
// Handshake channel interfaces for the citation reference parser.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface crp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  character;
    logic        end_of_line;

    modport source (output valid, output character, output end_of_line, input ready);
    modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

interface crp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] chapter;
    logic [15:0] verse;
    logic        last;

    modport source (output valid, output kind, output name_char, output chapter,
                    output verse, output last, input ready);
    modport sink   (input valid, input kind, input name_char, input chapter,
                    input verse, input last, output ready);
endinterface

`default_nettype wire

>>> sv/crp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/crp_front.sv
// Parser front end: takes one character per transfer, updates counters,
// writes the name store and queues a job per line. Uses crp_pkg, crp_if.
`timescale 1ns / 1ps
`default_nettype none

module crp_front #(
    parameter int NAME_BUFFER_SIZE = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    crp_in_if.sink             in_chan,
    input  wire logic          q_full,
    input  wire logic          q_empty,
    output logic               push,
    output crp_pkg::crp_job_t  job,
    output crp_pkg::crp_wr_t   wr
);

    localparam logic [crp_pkg::LEN_W-1:0] LIMIT = crp_pkg::LEN_W'(NAME_BUFFER_SIZE - 1);

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b0_0000_0001,
        PH_TILDE  = 9'b0_0000_0010,
        PH_QOPEN  = 9'b0_0000_0100,
        PH_QBODY  = 9'b0_0000_1000,
        PH_XAFTER = 9'b0_0001_0000,
        PH_XNUM   = 9'b0_0010_0000,
        PH_XQBODY = 9'b0_0100_0000,
        PH_YAFTER = 9'b0_1000_0000,
        PH_YNUM   = 9'b1_0000_0000
    } crp_phase_t;

    crp_phase_t                  phase_reg, phase_next;
    logic                        start_reg, start_next;
    logic                        failed_reg, failed_next;
    logic [1:0]                  tgt_reg, tgt_next;
    logic [15:0]                 chap_reg, chap_next;
    logic [15:0]                 verse_reg, verse_next;
    logic [crp_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [crp_pkg::LEN_W-1:0]   emit_reg, emit_next;

    logic                        accept;
    logic                        skip;
    logic                        between;
    logic [7:0]                  c;
    logic [3:0]                  digit;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == crp_pkg::NUM_MAX) ? crp_pkg::NUM_MAX : v + 16'd1;
    endfunction

    function automatic logic [15:0] sat_digit(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] r;
        r = {4'b0, v} * crp_pkg::RADIX + {16'b0, d};
        return (r > {4'b0, crp_pkg::NUM_MAX}) ? crp_pkg::NUM_MAX : r[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= crp_pkg::CH_ZERO) && (ch <= crp_pkg::CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == crp_pkg::CH_SPACE) || ((ch >= crp_pkg::CH_TAB) && (ch <= crp_pkg::CH_CR));
    endfunction

    // Hold off a name text character while an earlier line may still read the store.
    assign in_chan.ready = !q_full &&
                           !((phase_reg == PH_QBODY) && (tgt_reg == crp_pkg::TGT_NAME) &&
                             !failed_reg && !q_empty);

    assign accept = in_chan.valid && in_chan.ready;
    assign c      = in_chan.character;
    assign digit  = 4'(c - crp_pkg::CH_ZERO);

    always_comb
    begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        failed_next = failed_reg;
        tgt_next    = tgt_reg;
        chap_next   = chap_reg;
        verse_next  = verse_reg;
        len_next    = len_reg;
        emit_next   = emit_reg;
        push        = 1'b0;
        job         = '0;
        wr          = '0;
        skip        = 1'b0;
        between     = 1'b0;

        if (accept)
        begin
            if (in_chan.end_of_line)
            begin
                push         = 1'b1;
                job.bad      = failed_reg || (phase_reg == PH_TILDE) ||
                               (phase_reg == PH_QOPEN) || (phase_reg == PH_QBODY) ||
                               (phase_reg == PH_XQBODY);
                job.chapter  = chap_reg;
                job.verse    = verse_reg;
                job.name_len = len_reg;
                phase_next   = PH_IDLE;
                start_next   = 1'b1;
                failed_next  = 1'b0;
                emit_next    = '0;
            end
            else if (!failed_reg)
            begin
                if (start_reg)
                begin
                    start_next = 1'b0;
                    if (c == crp_pkg::CH_TILDE)
                    begin
                        phase_next = PH_TILDE;
                        skip       = 1'b1;
                    end
                end
                if (!skip)
                begin
                    case (phase_reg)
                        PH_QOPEN:
                        begin
                            if (c == crp_pkg::CH_QUOTE)
                            begin
                                phase_next = PH_QBODY;
                                emit_next  = '0;
                                if (tgt_reg == crp_pkg::TGT_NAME)
                                begin
                                    len_next = '0;
                                end
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_QBODY:
                        begin
                            if (c == crp_pkg::CH_QUOTE)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (emit_reg >= LIMIT)
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                if (tgt_reg == crp_pkg::TGT_NAME)
                                begin
                                    wr.en    = 1'b1;
                                    wr.addr  = emit_reg;
                                    wr.data  = c;
                                    len_next = emit_reg + 1'b1;
                                end
                                emit_next = emit_reg + 1'b1;
                            end
                        end
                        PH_XAFTER:
                        begin
                            if (c == crp_pkg::CH_QUOTE)
                            begin
                                chap_next  = '0;
                                phase_next = PH_XQBODY;
                            end
                            else if (is_digit(c))
                            begin
                                chap_next  = {12'b0, digit};
                                phase_next = PH_XNUM;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_XNUM:
                        begin
                            if (is_digit(c))
                            begin
                                chap_next = sat_digit(chap_reg, digit);
                            end
                            else
                            begin
                                between = 1'b1;
                            end
                        end
                        PH_XQBODY:
                        begin
                            if (c == crp_pkg::CH_QUOTE)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_YAFTER:
                        begin
                            if (is_digit(c))
                            begin
                                verse_next = {12'b0, digit};
                                phase_next = PH_YNUM;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_YNUM:
                        begin
                            if (is_digit(c))
                            begin
                                verse_next = sat_digit(verse_reg, digit);
                            end
                            else
                            begin
                                between = 1'b1;
                            end
                        end
                        default:
                        begin
                            between = 1'b1;
                        end
                    endcase

                    // Field letter or separator between fields.
                    if (between)
                    begin
                        phase_next = PH_IDLE;
                        if ((c == crp_pkg::CH_A) || (c == crp_pkg::CH_B) ||
                            (c == crp_pkg::CH_C))
                        begin
                            chap_next  = 16'd1;
                            verse_next = 16'd1;
                            tgt_next   = 2'(c - crp_pkg::CH_A);
                            phase_next = PH_QOPEN;
                        end
                        else if (c == crp_pkg::CH_X)
                        begin
                            chap_next  = sat_inc(chap_reg);
                            verse_next = 16'd1;
                            phase_next = PH_XAFTER;
                        end
                        else if (c == crp_pkg::CH_Y)
                        begin
                            verse_next = sat_inc(verse_reg);
                            phase_next = PH_YAFTER;
                        end
                        else if (!is_space(c))
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            start_reg  <= 1'b1;
            failed_reg <= 1'b0;
            tgt_reg    <= '0;
            chap_reg   <= '0;
            verse_reg  <= '0;
            len_reg    <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            failed_reg <= failed_next;
            tgt_reg    <= tgt_next;
            chap_reg   <= chap_next;
            verse_reg  <= verse_next;
            len_reg    <= len_next;
            emit_reg   <= emit_next;
        end
    end

`ifndef SYNTH
    // The name store is only rewritten once no queued line still reads it.
    a_write_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> q_empty)
        else $error("name store written while a line is pending");

    // Name length never passes the store size.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LIMIT)
        else $error("name length beyond store");
`endif

endmodule

`default_nettype wire

>>> sv/crp_queue.sv
// Short job queue between the parser and the result sequencer.
// Uses crp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire crp_pkg::crp_job_t  push_job,
    input  wire logic               pop,
    output crp_pkg::crp_job_t       head,
    output logic                    full,
    output logic                    empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    crp_pkg::crp_job_t  mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW:0]        count_reg, count_next;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

>>> sv/crp_back.sv
// Result sequencer: walks each queued line job, reads name characters from
// the store and drives the output channel. Uses crp_pkg, crp_if.
`timescale 1ns / 1ps
`default_nettype none

module crp_back #(
    parameter int ADDR_W = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire crp_pkg::crp_job_t  head,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    input  wire logic [7:0]         rd_data,
    crp_out_if.source               out_chan
);

    logic [crp_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic                       s1_valid_reg, s1_valid_next;
    crp_pkg::crp_res_t          s1_reg;
    logic                       out_valid_reg, out_valid_next;
    crp_pkg::crp_res_t          out_reg;
    logic [7:0]                 out_char_reg;

    crp_pkg::crp_res_t          desc;
    logic                       s1_ready;
    logic                       out_load;
    logic                       gen_fire;

    // Next result of the head job.
    always_comb
    begin
        desc = '0;
        if (head.bad)
        begin
            desc.kind = crp_pkg::KIND_ERROR;
            desc.last = 1'b1;
        end
        else if (head.chapter == '0)
        begin
            desc.kind = crp_pkg::KIND_NULL;
            desc.last = 1'b1;
        end
        else if (idx_reg < head.name_len)
        begin
            desc.kind = crp_pkg::KIND_NAME;
        end
        else
        begin
            desc.kind    = crp_pkg::KIND_REF;
            desc.chapter = head.chapter;
            desc.verse   = head.verse;
            desc.last    = 1'b1;
        end
    end

    assign out_load = !out_valid_reg || out_chan.ready;
    assign s1_ready = !s1_valid_reg || out_load;
    assign gen_fire = !empty && s1_ready;
    assign pop      = gen_fire && desc.last;
    assign rd_en    = gen_fire && (desc.kind == crp_pkg::KIND_NAME);
    assign rd_addr  = idx_reg[ADDR_W-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        if (gen_fire)
        begin
            idx_next = desc.last ? '0 : idx_reg + 1'b1;
        end
        s1_valid_next = gen_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
        out_valid_next = (s1_valid_reg && out_load) ? 1'b1 :
                         (out_chan.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            s1_reg <= desc;
        end
        if (s1_valid_reg && out_load)
        begin
            out_reg      <= s1_reg;
            out_char_reg <= (s1_reg.kind == crp_pkg::KIND_NAME) ? rd_data : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_chan.valid     = out_valid_reg;
    assign out_chan.kind      = out_reg.kind;
    assign out_chan.name_char = out_char_reg;
    assign out_chan.chapter   = out_reg.chapter;
    assign out_chan.verse     = out_reg.verse;
    assign out_chan.last      = out_reg.last;

`ifndef SYNTH
    // Only name characters leave a line open.
    a_last_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == (out_reg.kind != crp_pkg::KIND_NAME)))
        else $error("last flag does not match result kind");
`endif

endmodule

`default_nettype wire

>>> sv/citation_reference_parser_top.sv
// Top level of the citation reference parser: front end, job queue, result
// sequencer and name store. Uses crp_pkg, crp_if and all crp_ modules.
// Throughput: 1 input and 1 output transfer per cycle; output waits while the receiver
//   is not ready, input waits while the job queue is full, and a c-field text character
//   waits while an earlier line is queued.
// Reset: rst_n asynchronous, clears parser state, queue and output; name store kept.
`timescale 1ns / 1ps
`default_nettype none

module citation_reference_parser_top #(
    parameter int NAME_BUFFER_SIZE = 32,
    parameter int JOB_QUEUE_DEPTH  = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    crp_in_if.sink     in_chan,
    crp_out_if.source  out_chan
);

    // The store keeps one entry fewer than the buffer size.
    localparam int NAME_DEPTH = NAME_BUFFER_SIZE - 1;
    localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

    logic                  push;
    crp_pkg::crp_job_t     push_job;
    crp_pkg::crp_job_t     head;
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    crp_pkg::crp_wr_t      wr;
    logic                  rd_en;
    logic [NAME_AW-1:0]    rd_addr;
    logic [7:0]            rd_data;

    // Front end: classifies each character, tracks chapter/verse and the
    // name, and on end of line posts one job to the queue.
    crp_front #(
        .NAME_BUFFER_SIZE (NAME_BUFFER_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .q_full  (q_full),
        .q_empty (q_empty),
        .push    (push),
        .job     (push_job),
        .wr      (wr)
    );

    // Decouples line parsing from result delivery.
    crp_queue #(
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Book name characters; written by the front end, read by the back end.
    crp_ram #(
        .WIDTH (8),
        .DEPTH (NAME_DEPTH)
    ) u_name_store (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr[NAME_AW-1:0]),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back end: one result per cycle when not stalled, read stage then output register.
    crp_back #(
        .ADDR_W (NAME_AW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .out_chan (out_chan)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for citation_reference_parser_top: directed and random citation lines,
// results scored against a cycle-free behavioral model of the parser.
// Depends on crp_pkg, crp_if (crp_in_if, crp_out_if) and the parser RTL.

module testbench;

    localparam int NAME_SLOTS     = 31;    // name store depth, one less than the buffer size
    localparam int RANDOM_ITEMS   = 290;   // random input transfers after the directed lines
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES   = 24;    // quiet time at the end to catch stray results
    localparam int REPORT_LIMIT   = 10;

    // Where the parser stands within the fields of a line.
    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_TILDE,
        SCAN_QOPEN,
        SCAN_QTEXT,
        SCAN_XNEXT,
        SCAN_XNUM,
        SCAN_XNULL,
        SCAN_YNEXT,
        SCAN_YNUM
    } scan_phase_t;

    typedef struct {
        crp_pkg::crp_kind_t kind;
        logic [7:0]         name_char;
        logic [15:0]        chapter;
        logic [15:0]        verse;
        logic               last;
    } cite_result_t;

    // One input transfer; hold makes the sender wait for every awaited result first.
    typedef struct {
        logic [7:0] ch;
        logic       eol;
        bit         hold;
    } line_item_t;

    logic clk = 1'b0;
    logic rst_n;

    crp_in_if  char_chan ();
    crp_out_if ref_chan ();

    citation_reference_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (char_chan),
        .out_chan (ref_chan)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model state: a private copy, updated on each accepted input
    // transfer. Counters and the book name carry over from line to line.
    // ------------------------------------------------------------------
    scan_phase_t scan        = SCAN_IDLE;
    logic        line_start  = 1'b1;
    logic        line_failed = 1'b0;
    logic [1:0]  target      = 2'd0;
    logic [15:0] chapter_cnt = 16'd0;
    logic [15:0] verse_cnt   = 16'd0;
    logic [7:0]  name_mem [NAME_SLOTS];
    logic [4:0]  name_len    = 5'd0;
    logic [4:0]  text_count  = 5'd0;

    cite_result_t awaited_refs [$];   // results owed by the DUT, oldest first
    line_item_t   line_feed [$];      // input transfers not yet offered
    logic [7:0]   line_buf [$];       // characters of the line being built

    int fault_count = 0;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == crp_pkg::CH_SPACE) || (c >= crp_pkg::CH_TAB && c <= crp_pkg::CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= crp_pkg::CH_ZERO) && (c <= crp_pkg::CH_NINE);
    endfunction

    function automatic logic [15:0] step_sat(input logic [15:0] v);
        return (v == crp_pkg::NUM_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] digit_sat(input logic [15:0] v, input logic [7:0] c);
        logic [19:0] acc;
        acc = v * crp_pkg::RADIX + 20'(c - crp_pkg::CH_ZERO);
        return (acc > 20'(crp_pkg::NUM_MAX)) ? crp_pkg::NUM_MAX : acc[15:0];
    endfunction

    function automatic void post_result(input crp_pkg::crp_kind_t k, input logic [7:0] nc,
                                        input logic [15:0] chap, input logic [15:0] vs,
                                        input logic lst);
        cite_result_t r;
        r.kind      = k;
        r.name_char = nc;
        r.chapter   = chap;
        r.verse     = vs;
        r.last      = lst;
        awaited_refs.push_back(r);
    endfunction

    // Start of a new field, or a blank between fields.
    function automatic void start_field(input logic [7:0] c);
        scan = SCAN_IDLE;
        if (c == crp_pkg::CH_A || c == crp_pkg::CH_B || c == crp_pkg::CH_C)
        begin
            chapter_cnt = 16'd1;
            verse_cnt   = 16'd1;
            target      = 2'(c - crp_pkg::CH_A);
            scan        = SCAN_QOPEN;
        end
        else if (c == crp_pkg::CH_X)
        begin
            chapter_cnt = step_sat(chapter_cnt);
            verse_cnt   = 16'd1;
            scan        = SCAN_XNEXT;
        end
        else if (c == crp_pkg::CH_Y)
        begin
            verse_cnt = step_sat(verse_cnt);
            scan      = SCAN_YNEXT;
        end
        else if (!is_blank(c))
        begin
            line_failed = 1'b1;
        end
    endfunction

    function automatic void track_citation(input logic [7:0] c, input logic eol);
        logic spoiled;
        if (eol)
        begin
            // A line that stops inside a field, or right after the tilde, is bad.
            spoiled = line_failed ||
                      (scan inside {SCAN_TILDE, SCAN_QOPEN, SCAN_QTEXT, SCAN_XNULL});
            scan        = SCAN_IDLE;
            line_start  = 1'b1;
            line_failed = 1'b0;
            text_count  = 5'd0;
            if (spoiled)
                post_result(crp_pkg::KIND_ERROR, 8'd0, 16'd0, 16'd0, 1'b1);
            else if (chapter_cnt == 16'd0)
                post_result(crp_pkg::KIND_NULL, 8'd0, 16'd0, 16'd0, 1'b1);
            else
            begin
                for (int i = 0; i < name_len; i++)
                    post_result(crp_pkg::KIND_NAME, name_mem[i], 16'd0, 16'd0, 1'b0);
                post_result(crp_pkg::KIND_REF, 8'd0, chapter_cnt, verse_cnt, 1'b1);
            end
        end
        else if (!line_failed)
        begin
            if (line_start && c == crp_pkg::CH_TILDE)
            begin
                line_start = 1'b0;
                scan       = SCAN_TILDE;
            end
            else
            begin
                line_start = 1'b0;
                case (scan)
                    SCAN_QOPEN:
                    begin
                        if (c == crp_pkg::CH_QUOTE)
                        begin
                            scan       = SCAN_QTEXT;
                            text_count = 5'd0;
                            if (target == crp_pkg::TGT_NAME)
                                name_len = 5'd0;
                        end
                        else
                            line_failed = 1'b1;
                    end
                    SCAN_QTEXT:
                    begin
                        if (c == crp_pkg::CH_QUOTE)
                            scan = SCAN_IDLE;
                        else if (text_count >= NAME_SLOTS)
                            line_failed = 1'b1;
                        else
                        begin
                            // Only the c text lands in the name store.
                            if (target == crp_pkg::TGT_NAME)
                            begin
                                name_mem[text_count] = c;
                                name_len = text_count + 5'd1;
                            end
                            text_count = text_count + 5'd1;
                        end
                    end
                    SCAN_XNEXT:
                    begin
                        if (c == crp_pkg::CH_QUOTE)
                        begin
                            chapter_cnt = 16'd0;
                            scan        = SCAN_XNULL;
                        end
                        else if (is_digit(c))
                        begin
                            chapter_cnt = 16'(c - crp_pkg::CH_ZERO);
                            scan        = SCAN_XNUM;
                        end
                        else
                            line_failed = 1'b1;
                    end
                    SCAN_XNUM:
                    begin
                        if (is_digit(c))
                            chapter_cnt = digit_sat(chapter_cnt, c);
                        else
                            start_field(c);
                    end
                    SCAN_XNULL:
                    begin
                        if (c == crp_pkg::CH_QUOTE)
                            scan = SCAN_IDLE;
                    end
                    SCAN_YNEXT:
                    begin
                        if (is_digit(c))
                        begin
                            verse_cnt = 16'(c - crp_pkg::CH_ZERO);
                            scan      = SCAN_YNUM;
                        end
                        else
                            line_failed = 1'b1;
                    end
                    SCAN_YNUM:
                    begin
                        if (is_digit(c))
                            verse_cnt = digit_sat(verse_cnt, c);
                        else
                            start_field(c);
                    end
                    default:
                        start_field(c);
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Line builders. Characters collect in line_buf; flush_line turns them
    // into transfers followed by an end-of-line transfer.
    // ------------------------------------------------------------------
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == crp_pkg::CH_QUOTE);
        return b;
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic put_quoted(input int len);
        line_buf.push_back(crp_pkg::CH_QUOTE);
        repeat (len)
            line_buf.push_back(text_byte());
        line_buf.push_back(crp_pkg::CH_QUOTE);
    endtask

    // Mostly short numbers; long ones can push the counter into saturation.
    task automatic put_number();
        int digits;
        digits = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        repeat (digits)
            line_buf.push_back(crp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_blanks();
        int k;
        repeat ($urandom_range(0, 2))
        begin
            k = $urandom_range(0, 6);
            line_buf.push_back((k < 5) ? crp_pkg::CH_TAB + 8'(k) : crp_pkg::CH_SPACE);
        end
    endtask

    task automatic flush_line(input bit hold);
        line_item_t it;
        foreach (line_buf[i])
        begin
            it.ch   = line_buf[i];
            it.eol  = 1'b0;
            it.hold = hold && (i == 0);
            line_feed.push_back(it);
        end
        // The character of an end-of-line transfer is don't-care; keep it random.
        it.ch   = 8'($urandom_range(0, 255));
        it.eol  = 1'b1;
        it.hold = hold && (line_buf.size() == 0);
        line_feed.push_back(it);
        line_buf.delete();
    endtask

    // A line the parser accepts. A bare x or y can only be the last field,
    // since anything but a digit (or a quote after x) would follow it.
    task automatic build_good_line();
        int fields;
        int pick;
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(crp_pkg::CH_TILDE);
        fields = $urandom_range(1, 5);
        for (int f = 0; f < fields; f++)
        begin
            put_blanks();
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                line_buf.push_back(crp_pkg::CH_C);
                put_quoted(($urandom_range(0, 7) == 0) ? NAME_SLOTS : $urandom_range(0, 6));
            end
            else if (pick == 2)
            begin
                line_buf.push_back($urandom_range(0, 1) ? crp_pkg::CH_B : crp_pkg::CH_A);
                put_quoted($urandom_range(0, 6));
            end
            else if (pick < 6)
            begin
                line_buf.push_back(crp_pkg::CH_X);
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    put_quoted($urandom_range(0, 4));
                else if (pick > 1 || f != fields - 1)
                    put_number();
            end
            else
            begin
                line_buf.push_back(crp_pkg::CH_Y);
                if ($urandom_range(0, 3) != 0 || f != fields - 1)
                    put_number();
            end
        end
    endtask

    // A good line spoiled: cut short, one byte hit, an overlong text, or x/y
    // followed by a blank instead of a digit.
    task automatic build_broken_line();
        int variant;
        int cut;
        build_good_line();
        variant = $urandom_range(0, 3);
        if (variant == 0)
        begin
            cut = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > cut)
                line_buf.delete(line_buf.size() - 1);
        end
        else if (variant == 1)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        else if (variant == 2)
        begin
            line_buf.push_back(crp_pkg::CH_C);
            put_quoted(NAME_SLOTS + $urandom_range(1, 3));
        end
        else
        begin
            line_buf.push_back($urandom_range(0, 1) ? crp_pkg::CH_Y : crp_pkg::CH_X);
            line_buf.push_back(crp_pkg::CH_SPACE);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers transfers from line_feed at the falling edge, in
    // bursts of random length with random gaps. An item marked hold waits
    // until the DUT has handed back everything owed.
    // ------------------------------------------------------------------
    bit char_took  = 1'b0;   // set by the monitor when an input transfer happened
    int gap_left   = 0;
    int burst_left = 0;

    always @(negedge clk)
    begin
        line_item_t nxt;
        logic       drive_valid;
        logic [7:0] drive_char;
        logic       drive_eol;
        drive_valid = char_chan.valid;
        drive_char  = char_chan.character;
        drive_eol   = char_chan.end_of_line;
        if (!rst_n)
            drive_valid = 1'b0;
        else if (!char_chan.valid || char_took)
        begin
            drive_valid = 1'b0;
            if (gap_left != 0)
                gap_left--;
            else if (line_feed.size() != 0 &&
                     !(line_feed[0].hold && awaited_refs.size() != 0))
            begin
                nxt         = line_feed.pop_front();
                drive_valid = 1'b1;
                drive_char  = nxt.ch;
                drive_eol   = nxt.eol;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                    burst_left--;
            end
        end
        char_chan.valid       <= drive_valid;
        char_chan.character   <= drive_char;
        char_chan.end_of_line <= drive_eol;
    end

    // Receiver back-pressure: the mode is picked anew each time stall_tick[5:0] wraps to zero,
    // from always ready, one stall in four, coin toss and long stalls.
    logic [7:0] stall_tick = 8'd0;
    int         stall_mode = 0;

    always @(negedge clk)
    begin
        logic take;
        stall_tick = stall_tick + 8'd1;
        if (stall_tick[5:0] == 6'd0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       take = 1'b1;
            1:       take = (stall_tick[1:0] != 2'd0);
            2:       take = 1'($urandom_range(0, 1));
            default: take = (stall_tick[3:0] > 4'd9);
        endcase
        ref_chan.ready <= take;
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, score an output transfer against the
    // oldest awaited result, then feed an input transfer to the model.
    // Checking first keeps the order right when both happen together.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cite_result_t want;
        char_took = 1'b0;
        if (rst_n)
        begin
            if (ref_chan.valid && ref_chan.ready)
            begin
                if (awaited_refs.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result kind=%0d char=%h ch=%0d vs=%0d last=%b",
                                 $realtime, ref_chan.kind, ref_chan.name_char,
                                 ref_chan.chapter, ref_chan.verse, ref_chan.last);
                end
                else
                begin
                    want = awaited_refs.pop_front();
                    if (ref_chan.kind !== want.kind || ref_chan.name_char !== want.name_char ||
                        ref_chan.chapter !== want.chapter || ref_chan.verse !== want.verse ||
                        ref_chan.last !== want.last)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display("%0t: mismatch want kind=%0d char=%h ch=%0d vs=%0d last=%b",
                                     $realtime, want.kind, want.name_char, want.chapter,
                                     want.verse, want.last,
                                     "\n    got  kind=%0d char=%h ch=%0d vs=%0d last=%b",
                                     ref_chan.kind, ref_chan.name_char, ref_chan.chapter,
                                     ref_chan.verse, ref_chan.last);
                    end
                end
            end
            if (char_chan.valid && char_chan.ready)
            begin
                char_took = 1'b1;
                track_citation(char_chan.character, char_chan.end_of_line);
            end
        end
    end

    // Watchdog: too long without any transfer means the DUT is stuck or
    // owes results it will never send.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (char_chan.valid && char_chan.ready) || (ref_chan.valid && ref_chan.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int directed_count;
        int lines;
        int pick;

        rst_n                 = 1'b0;
        char_chan.valid       = 1'b0;
        char_chan.character   = 8'd0;
        char_chan.end_of_line = 1'b0;
        ref_chan.ready        = 1'b0;

        // Directed: tilde, a name, x step then load, bare y step.
        put_text("~c\"G\"x9y");
        flush_line(1'b0);
        // Null reference through a quoted x.
        put_text("x\"q\"");
        flush_line(1'b0);
        // Line that ends right after its tilde.
        put_text("~");
        flush_line(1'b0);
        // Both counters saturate; blank between fields.
        put_text("x70000 y99999");
        flush_line(1'b0);
        directed_count = line_feed.size();

        // First random line carries the longest name (most results per line)
        // and makes the sender wait for the directed results to drain.
        line_buf.push_back(crp_pkg::CH_C);
        put_quoted(NAME_SLOTS);
        line_buf.push_back(crp_pkg::CH_X);
        put_number();
        flush_line(1'b1);

        lines = 1;
        while (line_feed.size() - directed_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                build_good_line();
            else if (pick < 9)
                build_broken_line();
            else
                repeat ($urandom_range(0, 12))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            flush_line(lines % 40 == 0);
            lines++;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (line_feed.size() != 0 || char_chan.valid || awaited_refs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && awaited_refs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
